// ----- design/pipelined_prime_sieve_macros.svh -----
// Assertion macros for the prime sieve.
// Used by pipelined_prime_sieve.sv; expects clk_i and rst_ni in scope.
`ifndef PIPELINED_PRIME_SIEVE_MACROS_SVH
`define PIPELINED_PRIME_SIEVE_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pps: assertion failed");

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pps: assertion failed");

`endif

// ----- design/pps_pkg.sv -----
// Shared types and constants for the prime sieve.
// No dependencies.
package pps_pkg;

  localparam int NumStagesDef  = 16;
  localparam int ValueWidthDef = 16;
  localparam int ValueBits     = 16;

  typedef struct packed {
    logic alive;
    logic done;
  } pps_tok_t;

endpackage

// ----- design/pipelined_prime_sieve.sv -----
// Prime sieve top level: chain of sieve cells, phase counter, output register.
// Depends on pps_pkg, pps_cell and pipelined_prime_sieve_macros.svh.
//
// Items move down a chain of NUM_STAGES cells in lockstep; each cell keeps an
// item while it works out the remainder by its prime, one bit per cycle when
// the chain is not held. A new item is taken only at the cycle the cells hand
// items on, so the first cell takes a new item only when it hands its last one
// on. Results appear in input order; values below two and values divisible
// by a stored prime give no result. While a result waits stalled in the
// output register and another is due, the chain holds.
module pipelined_prime_sieve #(
  parameter int NUM_STAGES  = pps_pkg::NumStagesDef,
  parameter int VALUE_WIDTH = pps_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pps_pkg::ValueBits-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pps_pkg::ValueBits-1:0] out_prime_value_o,
  output logic                          out_overflow_o
);
  import pps_pkg::*;

  `include "pipelined_prime_sieve_macros.svh"

  localparam int BitW = $clog2(VALUE_WIDTH);

  logic [BitW-1:0]        bit_idx_q, bit_idx_d;
  logic                   first, last;
  logic                   adv;
  logic                   emit;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] vin;
  pps_tok_t               tok_chain [NUM_STAGES+1];
  logic [VALUE_WIDTH-1:0] val_chain [NUM_STAGES+1];
  logic [NUM_STAGES-1:0]  filled_vec;
  logic                   out_valid_q;
  logic [ValueBits-1:0]   out_value_q;
  logic                   out_ovf_q;

  assign first = (bit_idx_q == BitW'(VALUE_WIDTH - 1));
  assign last  = (bit_idx_q == '0);
  assign emit  = last && tok_chain[NUM_STAGES].alive;
  assign adv   = !(emit && out_valid_q && out_stall_i);
  assign out_load   = emit && adv;
  assign in_stall_o = !(adv && last);

  assign vin                = VALUE_WIDTH'(in_value_i);
  assign tok_chain[0].alive = in_valid_i && (vin > VALUE_WIDTH'(1));
  assign tok_chain[0].done  = 1'b0;
  assign val_chain[0]       = vin;

  always_comb begin
    bit_idx_d = bit_idx_q;
    if (adv) begin
      bit_idx_d = last ? BitW'(VALUE_WIDTH - 1) : bit_idx_q - BitW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_idx_q <= BitW'(VALUE_WIDTH - 1);
    end else begin
      bit_idx_q <= bit_idx_d;
    end
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    pps_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .BIT_W       (BitW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (adv),
      .first_i   (first),
      .last_i    (last),
      .bit_idx_i (bit_idx_q),
      .tok_i     (tok_chain[g]),
      .value_i   (val_chain[g]),
      .tok_o     (tok_chain[g+1]),
      .value_o   (val_chain[g+1]),
      .filled_o  (filled_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= ValueBits'(val_chain[NUM_STAGES]);
      out_ovf_q   <= !tok_chain[NUM_STAGES].done;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_prime_value_o = out_value_q;
  assign out_overflow_o    = out_ovf_q;

  `PPS_ASSERT_IMP(a_accept_on_handoff, in_valid_i && !in_stall_o, last)
  `PPS_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || !out_stall_i)
  `PPS_ASSERT_NXT(a_hold_on_stall, !adv, $stable(bit_idx_q))
  `PPS_ASSERT_IMP(a_filled_prefix, 1'b1, (filled_vec & (filled_vec + NUM_STAGES'(1))) == '0)

endmodule

// ----- design/pps_cell.sv -----
// One sieve cell: holds a captured prime and runs a bit-serial remainder.
// Depends on pps_pkg.
module pps_cell #(
  parameter int VALUE_WIDTH = 16,
  parameter int BIT_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  logic [BIT_W-1:0]       bit_idx_i,
  input  pps_pkg::pps_tok_t      tok_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output pps_pkg::pps_tok_t      tok_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   filled_o
);
  import pps_pkg::*;

  pps_tok_t               tok_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] prime_q;
  logic                   filled_q;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] rem_in;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   trial_sub;
  logic                   drop;
  logic                   capture;

  always_comb begin
    rem_in    = first_i ? '0 : rem_q;
    trial     = {rem_in, value_q[bit_idx_i]};
    trial_sub = trial - {1'b0, prime_q};
    if (trial >= {1'b0, prime_q}) begin
      rem_d = trial_sub[VALUE_WIDTH-1:0];
    end else begin
      rem_d = trial[VALUE_WIDTH-1:0];
    end
    drop        = tok_q.alive && !tok_q.done && filled_q && (rem_d == '0);
    tok_o.alive = tok_q.alive && !drop;
    tok_o.done  = tok_q.done;
    capture     = tok_i.alive && !tok_i.done && !filled_q;
  end

  assign value_o  = value_q;
  assign filled_o = filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      filled_q <= 1'b0;
      prime_q  <= '0;
    end else if (step_i && last_i) begin
      tok_q.alive <= tok_i.alive;
      tok_q.done  <= tok_i.done || capture;
      if (capture) begin
        filled_q <= 1'b1;
        prime_q  <= value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rem_q <= rem_d;
      if (last_i) begin
        value_q <= value_i;
      end
    end
  end

endmodule

// ----- bench/tb_pipelined_prime_sieve.sv -----
// Self-checking bench for pipelined_prime_sieve: directed table, then random stream.
// Expected primes come from a local sieve predictor or a typed directed row; needs pps_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_pipelined_prime_sieve;

  localparam int NStages       = pps_pkg::NumStagesDef;
  localparam int RandomItems   = 800;
  localparam int HoldOffCycles = 1500;
  localparam int TailCycles    = 600;
  localparam int CycleLimit    = 1000000;

  typedef logic [pps_pkg::ValueBits-1:0] value_t;

  typedef struct packed {
    value_t prime_value;
    logic   overflow;
  } prime_t;

  // How a directed row is checked: by the predictor, or by a typed result.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_STORED,
    CHK_OVERFLOW
  } row_check_e;

  typedef struct packed {
    value_t     value;
    row_check_e check;
  } stim_row_t;

  // Fills all sixteen stages, then hits the full chain.
  localparam stim_row_t DirectedRows [25] = '{
    '{16'd0,     CHK_NONE},
    '{16'd1,     CHK_NONE},
    '{16'd65535, CHK_STORED},
    '{16'd65535, CHK_NONE},
    '{16'd2,     CHK_STORED},
    '{16'd4,     CHK_NONE},
    '{16'd3,     CHK_STORED},
    '{16'd9,     CHK_NONE},
    '{16'd32768, CHK_NONE},
    '{16'd25,    CHK_MODEL},
    '{16'd5,     CHK_MODEL},
    '{16'd7,     CHK_MODEL},
    '{16'd11,    CHK_MODEL},
    '{16'd13,    CHK_MODEL},
    '{16'd17,    CHK_MODEL},
    '{16'd19,    CHK_MODEL},
    '{16'd23,    CHK_MODEL},
    '{16'd29,    CHK_MODEL},
    '{16'd31,    CHK_MODEL},
    '{16'd37,    CHK_MODEL},
    '{16'd41,    CHK_MODEL},
    '{16'd43,    CHK_MODEL},
    '{16'd47,    CHK_OVERFLOW},
    '{16'd49,    CHK_NONE},
    '{16'd53,    CHK_OVERFLOW}
  };

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  value_t in_value_i;
  logic   out_valid_o;
  logic   out_stall_i;
  value_t out_prime_value_o;
  logic   out_overflow_o;

  value_t sieve_prime [NStages];
  logic   sieve_full  [NStages];
  prime_t prime_queue [$];
  int     mismatches  = 0;
  int     primes_seen = 0;
  int     cycle_count = 0;

  pipelined_prime_sieve u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_prime_value_o(out_prime_value_o),
    .out_overflow_o   (out_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("%0t timeout", $time);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Returns 1 when the value survives; updates the stage copy.
  function automatic logic sieve_step(input value_t v, output prime_t res);
    int slot;
    slot = -1;
    res.prime_value = v;
    res.overflow    = 1'b0;
    if (v < 2) return 1'b0;
    for (int s = 0; s < NStages; s++) begin
      if (sieve_full[s]) begin
        if (sieve_prime[s] != 0 && (v % sieve_prime[s]) == 0) return 1'b0;
      end else if (slot < 0) begin
        slot = s;
      end
    end
    if (slot >= 0) begin
      sieve_prime[slot] = v;
      sieve_full[slot]  = 1'b1;
    end else begin
      res.overflow = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic offer(input value_t v, input row_check_e check);
    int     gap;
    int     pick;
    logic   survives;
    prime_t res;
    pick = $urandom_range(99);
    if (pick < 50) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 17);
    else gap = $urandom_range(30, 120);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    survives = sieve_step(v, res);
    case (check)
      CHK_MODEL: begin
        if (survives) prime_queue.push_back(res);
      end
      CHK_STORED:   prime_queue.push_back('{prime_value: v, overflow: 1'b0});
      CHK_OVERFLOW: prime_queue.push_back('{prime_value: v, overflow: 1'b1});
      default: ;
    endcase
  endtask

  initial begin : stimulus
    value_t walk;
    value_t v;
    int     pick;
    foreach (sieve_full[s]) begin
      sieve_full[s]  = 1'b0;
      sieve_prime[s] = '0;
    end
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedRows[i]) offer(DirectedRows[i].value, DirectedRows[i].check);
    walk = 16'd54;
    repeat (RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        walk = walk + value_t'($urandom_range(1, 6));
        v = walk;
      end else if (pick < 85) begin
        v = value_t'($urandom);
      end else begin
        v = value_t'($urandom_range(3));
      end
      offer(v, CHK_MODEL);
    end
    in_valid_i <= 1'b0;
    while (prime_queue.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side: random stall runs plus one long hold-off to back up the chain.
  initial begin : receiver
    int   run;
    int   pick;
    logic held;
    held = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && primes_seen >= 30) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        run = HoldOffCycles;
      end else begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(1, 40);
        end else if (pick < 90) begin
          out_stall_i <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(20, 80);
        end
      end
      repeat (run) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    prime_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      primes_seen++;
      if (prime_queue.size() == 0) begin
        report_mismatch("unexpected item, prime_value", int'(out_prime_value_o), 0);
      end else begin
        want = prime_queue.pop_front();
        if (out_prime_value_o !== want.prime_value)
          report_mismatch("prime_value", int'(out_prime_value_o), int'(want.prime_value));
        if (out_overflow_o !== want.overflow)
          report_mismatch("overflow", int'(out_overflow_o), int'(want.overflow));
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+design
design/pps_pkg.sv
design/pps_cell.sv
design/pipelined_prime_sieve.sv
bench/tb_pipelined_prime_sieve.sv
